/* rtl/core/pds_pkg.sv */
// pds_pkg: shared command and status types for the prime divisor sum block
// used by pds_ctrl, pds_datapath and the top level; no dependencies

package pds_pkg;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture a new number, reset trial divisor
    logic div_start;  // start a division of rest by the trial divisor
    logic take_quot;  // divisor divides rest: replace rest by quotient
    logic next_p;     // advance to the next trial divisor
    logic finish;     // form the result and present it on the output
  } pds_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic sq_gt_rest; // square of the trial divisor exceeds rest
    logic div_done;   // division result is ready (one-cycle pulse)
    logic rem_zero;   // remainder of the last division is zero
    logic out_free;   // output register can take a new result
  } pds_status_t;

endpackage

/* rtl/core/pds_divider.sv */
// pds_divider: restoring divider, one quotient bit per cycle
// standalone; no package dependency

module pds_divider #(
  parameter int W = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic         rem_zero
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic             ge;

  // one restoring step
  assign shifted = {rem, quo[W-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  // control: busy flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], ge};
    end
  end

  assign quotient = quo;
  assign rem_zero = (rem == '0);

endmodule

/* rtl/core/pds_datapath.sv */
// pds_datapath: number, rest, trial divisor, running sum and output register
// depends on pds_pkg and pds_divider

module pds_datapath #(
  parameter int W = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  pds_pkg::pds_cmd_t   cmd,
  output pds_pkg::pds_status_t status,
  input  logic [W-1:0]        number_in,
  output logic [W-1:0]        divisor_sum,
  output logic                out_valid,
  input  logic                out_ready
);

  import pds_pkg::*;

  logic [W-1:0] value;
  logic [W-1:0] rest;
  logic [W-1:0] total;
  logic [W-1:0] p;
  logic [W:0]   sq;
  logic         found;
  logic         div_done;
  logic [W-1:0] quotient;
  logic         rem_zero;
  logic [W-1:0] tail;
  logic [W-1:0] dividend;

  // a repeated division starts from the fresh quotient, not the old rest
  assign dividend = cmd.take_quot ? quotient : rest;

  // shared iterative divider: rest / p, or quotient / p on a repeated division
  pds_divider #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (p),
    .done     (div_done),
    .quotient (quotient),
    .rem_zero (rem_zero)
  );

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= number_in;
      rest  <= number_in;
      total <= '0;
      p     <= W'(2);
      sq    <= (W + 1)'(4);
      found <= 1'b0;
    end else if (cmd.take_quot) begin
      rest  <= quotient;
      found <= 1'b1;
      if (!found) begin
        total <= total + p;
      end
    end else if (cmd.next_p) begin
      p     <= p + 1'b1;
      sq    <= sq + {p, 1'b1};
      found <= 1'b0;
    end
  end

  // leftover prime cofactor, unless it is the number itself
  assign tail = ((rest > W'(1)) && (rest != value)) ? rest : '0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      divisor_sum <= total + tail;
    end
  end

  // status back to the controller
  always_comb begin
    status.sq_gt_rest = sq > {1'b0, rest};
    status.div_done   = div_done;
    status.rem_zero   = rem_zero;
    status.out_free   = !out_valid || out_ready;
  end

endmodule

/* rtl/core/pds_ctrl.sv */
// pds_ctrl: state machine sequencing trial division over candidate divisors
// depends on pds_pkg

module pds_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output pds_pkg::pds_cmd_t    cmd,
  input  pds_pkg::pds_status_t status
);

  import pds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_FINAL = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.sq_gt_rest) begin
          state_next = S_FINAL;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            // divide out the factor again with the same divisor
            cmd.take_quot = 1'b1;
            cmd.div_start = 1'b1;
          end else begin
            cmd.next_p = 1'b1;
            state_next = S_CHECK;
          end
        end
      end
      S_FINAL: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/prime_divisor_sum.sv */
// prime_divisor_sum: sum of distinct prime divisors, excluding the number itself
// run time: one divider run per candidate divisor up to the square root of the rest, plus
// one more per prime factor divided out; each run is paced by the shared one-bit-per-cycle divider
// throughput: one transaction at a time; a result waiting in the output register
// does not stop the next transaction from being taken. reset: synchronous, no sweep
// depends on pds_pkg, pds_ctrl, pds_datapath

module prime_divisor_sum #(
  parameter int NUMBER_WIDTH = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [NUMBER_WIDTH-1:0] number_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [NUMBER_WIDTH-1:0] divisor_sum
);

  import pds_pkg::*;

  pds_cmd_t    cmd;
  pds_status_t status;

  pds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  pds_datapath #(.W(NUMBER_WIDTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .number_in   (number_in),
    .divisor_sum (divisor_sum),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

endmodule
